@@ hw/rtl/bfr_pkg.sv @@
package bfr_pkg;

  // Default sizes of the queue.
  localparam int DEPTH_DEF        = 16;
  localparam int HANDLE_WIDTH_DEF = 32;

  // Fixed widths of the request and result fields.
  localparam int OP_FW     = 2;
  localparam int HANDLE_FW = 32;
  localparam int STATUS_FW = 2;
  localparam int COUNT_FW  = 5;

  // Operation codes carried by a request.
  localparam logic [OP_FW-1:0] OP_PUSH   = 2'd0;
  localparam logic [OP_FW-1:0] OP_POP    = 2'd1;
  localparam logic [OP_FW-1:0] OP_REMOVE = 2'd2;

  // Result status codes.
  typedef enum logic [STATUS_FW-1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } bfr_status_t;

  // Controller states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_PUSH,
    S_POP_RD,
    S_POP_TAKE,
    S_RM,
    S_EMIT
  } bfr_state_t;

  // Request payload.
  typedef struct packed {
    logic [OP_FW-1:0]     op;
    logic [HANDLE_FW-1:0] handle_in;
  } bfr_in_t;

  // Result payload.
  typedef struct packed {
    logic [STATUS_FW-1:0] status;
    logic [HANDLE_FW-1:0] handle_out;
    logic [COUNT_FW-1:0]  count;
    logic                 is_empty;
  } bfr_out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic        capture;
    bfr_status_t status;
    logic        push_wr;
    logic        pop_rd;
    logic        pop_take;
    logic        rm_start;
    logic        rm_read;
    logic        rm_finish;
    logic        emit;
  } bfr_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic full;
    logic empty;
    logic scan_more;
    logic rd_pend;
    logic out_free;
  } bfr_stat_t;

endpackage

@@ hw/rtl/bfr_ctrl.sv @@
module bfr_ctrl
  import bfr_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic [OP_FW-1:0] in_op,
  output logic             in_stall,
  input  bfr_stat_t        stat,
  output bfr_cmd_t         cmd
);

  bfr_state_t state_r, state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          case (in_op)
            OP_PUSH:   state_nxt = stat.full ? S_EMIT : S_PUSH;
            OP_POP:    state_nxt = stat.empty ? S_EMIT : S_POP_RD;
            OP_REMOVE: state_nxt = S_RM;
            default:   state_nxt = S_EMIT;
          endcase
        end
      end
      S_PUSH:     state_nxt = S_EMIT;
      S_POP_RD:   state_nxt = S_POP_TAKE;
      S_POP_TAKE: state_nxt = S_EMIT;
      S_RM: begin
        if (!stat.scan_more && !stat.rd_pend) begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (stat.out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    cmd      = '0;
    cmd.status = ST_DONE;
    in_stall = 1'b1;
    case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.capture = 1'b1;
          case (in_op)
            OP_PUSH:   cmd.status = stat.full ? ST_FULL : ST_DONE;
            OP_POP:    cmd.status = stat.empty ? ST_EMPTY : ST_DONE;
            OP_REMOVE: cmd.rm_start = 1'b1;
            default:   cmd.status = ST_DONE;
          endcase
        end
      end
      S_PUSH:     cmd.push_wr = 1'b1;
      S_POP_RD:   cmd.pop_rd = 1'b1;
      S_POP_TAKE: cmd.pop_take = 1'b1;
      S_RM: begin
        cmd.rm_read   = stat.scan_more;
        cmd.rm_finish = !stat.scan_more && !stat.rd_pend;
      end
      S_EMIT:  cmd.emit = stat.out_free;
      default: cmd = '0;
    endcase
  end

  // A request is taken only in the idle state.
  a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r != S_IDLE))
    else $error("request accepted but controller stayed idle");

  // A result is only handed over when the output register can take it.
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> stat.out_free)
    else $error("result emitted into a busy output register");

  // The remove scan leaves only after its reads have drained.
  a_rm_drain: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rm_finish |-> (!stat.rd_pend && !cmd.rm_read))
    else $error("remove finished with a read outstanding");

endmodule

@@ hw/rtl/bfr_dpath.sv @@
module bfr_dpath
  import bfr_pkg::*;
#(
  parameter int DEPTH        = DEPTH_DEF,
  parameter int HANDLE_WIDTH = HANDLE_WIDTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  bfr_in_t   in_data,
  input  bfr_cmd_t  cmd,
  output bfr_stat_t stat,
  output logic      out_valid,
  input  logic      out_stall,
  output bfr_out_t  out_data
);

  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = $clog2(2 * DEPTH);

  // Position base + off in the circular store.
  function automatic logic [IW-1:0] wrap_add(input logic [IW-1:0] base,
                                             input logic [CW-1:0] off);
    logic [SW-1:0] sum;
    sum = SW'(base) + SW'(off);
    if (sum >= SW'(DEPTH)) begin
      sum = sum - SW'(DEPTH);
    end
    return sum[IW-1:0];
  endfunction

  logic [HANDLE_WIDTH-1:0] mem [DEPTH];
  logic [HANDLE_WIDTH-1:0] rd_data_r;

  logic [IW-1:0] head_r, head_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] scan_idx_r, scan_idx_nxt;
  logic [CW-1:0] kept_r, kept_nxt;
  logic          rd_pend_r, rd_pend_nxt;
  logic          out_valid_r, out_valid_nxt;

  logic [HANDLE_WIDTH-1:0] handle_r;
  logic [HANDLE_WIDTH-1:0] popped_r;
  logic [STATUS_FW-1:0]    status_r;
  bfr_out_t                out_data_r;

  logic [IW-1:0]           tail;
  logic [IW-1:0]           scan_addr;
  logic [IW-1:0]           keep_addr;
  logic                    rm_keep;
  logic                    wr_en;
  logic [IW-1:0]           wr_addr;
  logic [HANDLE_WIDTH-1:0] wr_data;
  logic                    rd_en;
  logic [IW-1:0]           rd_addr;

  // Store port selection.
  always_comb begin
    tail      = wrap_add(head_r, count_r);
    scan_addr = wrap_add(head_r, scan_idx_r);
    keep_addr = wrap_add(head_r, kept_r);
    rm_keep   = rd_pend_r && (rd_data_r != handle_r);
    wr_en     = cmd.push_wr || rm_keep;
    wr_addr   = cmd.push_wr ? tail : keep_addr;
    wr_data   = cmd.push_wr ? handle_r : rd_data_r;
    rd_en     = cmd.pop_rd || cmd.rm_read;
    rd_addr   = cmd.pop_rd ? head_r : scan_addr;
  end

  // Entry store with one write and one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // Pointer, count and scan bookkeeping.
  always_comb begin
    head_nxt     = head_r;
    count_nxt    = count_r;
    scan_idx_nxt = scan_idx_r;
    kept_nxt     = kept_r;
    rd_pend_nxt  = cmd.rm_read;
    if (cmd.push_wr) begin
      count_nxt = count_r + CW'(1);
    end
    if (cmd.pop_rd) begin
      head_nxt  = (head_r == IW'(DEPTH - 1)) ? '0 : head_r + IW'(1);
      count_nxt = count_r - CW'(1);
    end
    if (cmd.rm_start) begin
      scan_idx_nxt = '0;
      kept_nxt     = '0;
    end
    if (cmd.rm_read) begin
      scan_idx_nxt = scan_idx_r + CW'(1);
    end
    if (rm_keep) begin
      kept_nxt = kept_r + CW'(1);
    end
    if (cmd.rm_finish) begin
      count_nxt = kept_r;
    end
  end

  // Output register handover.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      count_r     <= '0;
      scan_idx_r  <= '0;
      kept_r      <= '0;
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      scan_idx_r  <= scan_idx_nxt;
      kept_r      <= kept_nxt;
      rd_pend_r   <= rd_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Request payload and result fields.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      handle_r <= HANDLE_WIDTH'(in_data.handle_in);
      status_r <= cmd.status;
      popped_r <= '0;
    end else if (cmd.pop_take) begin
      popped_r <= rd_data_r;
    end
    if (cmd.emit) begin
      out_data_r.status     <= status_r;
      out_data_r.handle_out <= HANDLE_FW'(popped_r);
      out_data_r.count      <= COUNT_FW'(count_r);
      out_data_r.is_empty   <= (count_r == '0);
    end
  end

  // Status to the controller.
  always_comb begin
    stat.full      = (count_r == CW'(DEPTH));
    stat.empty     = (count_r == '0);
    stat.scan_more = (scan_idx_r < count_r);
    stat.rd_pend   = rd_pend_r;
    stat.out_free  = !out_valid_r || !out_stall;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // The count never passes the capacity.
  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("entry count exceeds capacity");

  // A push write grows the count by one, a pop read only happens with an entry.
  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.push_wr |=> (count_r == $past(count_r) + CW'(1)))
    else $error("push did not grow the count by one");

  a_pop_entry: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.pop_rd |-> (count_r != '0))
    else $error("pop read from an empty queue");

  // Compaction never keeps more entries than it has scanned.
  a_kept_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rm_finish |-> (kept_r <= count_r))
    else $error("remove kept more entries than were held");

endmodule

@@ hw/rtl/bounded_fifo_with_remove_core.sv @@
// Channel   Ports                            Moves
// -------   ------------------------------   ---------------------------------------
// request   in_valid, in_stall, in_data      op and handle_in
// result    out_valid, out_stall, out_data   status, handle_out, count, is_empty
//
// One request at a time; the entry store has one write and one registered read port.
// Push writes the tail or reports full; pop reads and takes the head or reports empty.
// Remove makes one store read per entry; an unused op goes straight to its result.
// A result waits in the output register while the next request is already taken.
// Reset (rst_n low, synchronous) empties the queue; store contents are not cleared.
// Out_stall only holds the result; a new result waits until the register frees up.
module bounded_fifo_with_remove_core
  import bfr_pkg::*;
#(
  parameter int DEPTH        = DEPTH_DEF,
  parameter int HANDLE_WIDTH = HANDLE_WIDTH_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  bfr_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output bfr_out_t out_data
);

  bfr_cmd_t  cmd;
  bfr_stat_t stat;

  // Sequencing of each request.
  bfr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_op    (in_data.op),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Store, pointers and output register.
  bfr_dpath #(
    .DEPTH        (DEPTH),
    .HANDLE_WIDTH (HANDLE_WIDTH)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
